FILE: src/pb_pkg.sv
package pb_pkg;

  // largest packet, literal or run
  localparam int MAX_PACKET_DEF = 128;

  // command queue between front and back
  localparam int Q_DEPTH = 4;

  typedef logic [7:0] data_t;
  typedef logic [7:0] len_t;

  // packet kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_RUN,
    CMD_LIT_BYTE,
    CMD_LIT_BANK
  } cmd_kind_t;

  // one packet to be written out
  typedef struct packed {
    cmd_kind_t kind;
    len_t      len;
    data_t     data;
    logic      bank;
    logic      end_item;
    logic      eos;
  } cmd_t;

  // commands produced by one input transfer
  typedef struct packed {
    logic [1:0] n;
    cmd_t       c0;
    cmd_t       c1;
  } push_t;

  // literal store write port
  typedef struct packed {
    logic  en;
    logic  bank;
    len_t  idx;
    data_t data;
  } wr_t;

  // bank handed back once its literal is sent
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

FILE: src/pb_if.sv
interface pb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

interface pb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last_of_item;
  logic        stream_done;

  modport source (output valid, out_bytes, byte_count, last_of_item, stream_done,
                  input ready);
  modport sink (input valid, out_bytes, byte_count, last_of_item, stream_done,
                output ready);
endinterface

FILE: src/pb_front.sv
module pb_front #(
  parameter int MAX_PACKET = pb_pkg::MAX_PACKET_DEF
) (
  input  logic          clk,
  input  logic          rst,
  pb_in_if.sink         din,
  input  logic          q_room,
  input  pb_pkg::rel_t  rel,
  output pb_pkg::push_t push,
  output pb_pkg::wr_t   wr
);

  localparam pb_pkg::len_t MaxLen = pb_pkg::len_t'(MAX_PACKET);

  logic         pend_run;
  pb_pkg::len_t pend_len;
  pb_pkg::data_t prev;
  logic         wr_bank;
  logic [1:0]   busy;

  pb_pkg::data_t b;
  logic          eos;
  logic          h0;
  logic          hand;
  logic          hand2;
  logic          need_bank;
  logic          nrun;
  pb_pkg::len_t  nlen;
  logic          wbank;
  pb_pkg::cmd_t  c0;
  pb_pkg::cmd_t  fl;
  pb_pkg::wr_t   wr_c;
  logic          accept;
  logic [1:0]    busy_next;

  assign b   = din.data_byte;
  assign eos = din.end_of_stream;

  // classify the byte against the pending packet
  always_comb begin
    h0    = 1'b0;
    hand  = 1'b0;
    nrun  = pend_run;
    nlen  = pend_len;
    wbank = wr_bank;
    c0    = '{kind: pb_pkg::CMD_RUN, len: pend_len, data: prev, bank: wr_bank,
              end_item: 1'b0, eos: 1'b0};
    wr_c  = '{en: 1'b0, bank: wr_bank, idx: '0, data: b};
    if (pend_len == '0) begin
      nlen    = 8'd1;
      nrun    = 1'b0;
      wr_c.en = 1'b1;
    end else if (pend_len >= MaxLen) begin
      h0     = 1'b1;
      hand   = !pend_run;
      if (!pend_run) begin
        c0.kind = pb_pkg::CMD_LIT_BANK;
      end
      nlen      = 8'd1;
      nrun      = 1'b0;
      wbank     = wr_bank ^ !pend_run;
      wr_c.en   = 1'b1;
      wr_c.bank = wr_bank ^ !pend_run;
    end else if (b == prev) begin
      if (pend_run) begin
        nlen = pend_len + 8'd1;
      end else begin
        if (pend_len >= 8'd2) begin
          h0      = 1'b1;
          hand    = 1'b1;
          c0.kind = pb_pkg::CMD_LIT_BANK;
          c0.len  = pend_len - 8'd1;
          wbank   = !wr_bank;
        end
        nlen = 8'd2;
        nrun = 1'b1;
      end
    end else begin
      if (pend_run) begin
        h0      = 1'b1;
        nlen    = 8'd1;
        nrun    = 1'b0;
        wr_c.en = 1'b1;
      end else begin
        wr_c.en  = 1'b1;
        wr_c.idx = pend_len;
        nlen     = pend_len + 8'd1;
      end
    end
  end

  // store write only on an accepted transfer
  assign wr = '{en: wr_c.en && accept, bank: wr_c.bank, idx: wr_c.idx, data: wr_c.data};

  // end-of-stream flush of whatever is pending afterwards
  always_comb begin
    fl = '{kind: pb_pkg::CMD_RUN, len: nlen, data: b, bank: wbank,
           end_item: 1'b1, eos: 1'b1};
    if (!nrun) begin
      fl.kind = (nlen == 8'd1) ? pb_pkg::CMD_LIT_BYTE : pb_pkg::CMD_LIT_BANK;
    end
    hand2 = eos && !nrun && (nlen >= 8'd2);
  end

  assign need_bank = hand || hand2;
  assign din.ready = q_room && (!need_bank || !busy[!wr_bank]);
  assign accept    = din.valid && din.ready;

  // commands for the queue
  always_comb begin
    push.c0 = c0;
    push.c1 = fl;
    push.n  = 2'd0;
    if (accept) begin
      if (h0 && eos) begin
        push.n = 2'd2;
      end else if (h0) begin
        push.n           = 2'd1;
        push.c0.end_item = 1'b1;
      end else if (eos) begin
        push.n  = 2'd1;
        push.c0 = fl;
      end
    end
  end

  // bank ownership
  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (accept && need_bank) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  // pending packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_run <= 1'b0;
      pend_len <= '0;
      prev     <= '0;
      wr_bank  <= 1'b0;
      busy     <= '0;
    end else begin
      busy <= busy_next;
      if (accept) begin
        pend_run <= eos ? 1'b0 : nrun;
        pend_len <= eos ? '0 : nlen;
        prev     <= b;
        wr_bank  <= wr_bank ^ need_bank;
      end
    end
  end

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (rst) pend_len <= MaxLen)
    else $error("pending length beyond packet limit");
  a_run_len: assert property (@(posedge clk) disable iff (rst) pend_run |-> pend_len >= 8'd2)
    else $error("run pending with fewer than two bytes");
  a_bank_own: assert property (@(posedge clk) disable iff (rst) !busy[wr_bank])
    else $error("front writing into a bank still being sent");
`endif

endmodule

FILE: src/pb_cmd_queue.sv
module pb_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  pb_pkg::push_t push,
  input  logic          pop,
  output logic          room,
  output logic          head_valid,
  output pb_pkg::cmd_t  head
);

  localparam int PtrW = $clog2(pb_pkg::Q_DEPTH);
  localparam int CntW = $clog2(pb_pkg::Q_DEPTH + 1);

  pb_pkg::cmd_t q [pb_pkg::Q_DEPTH];
  logic [PtrW-1:0] wp;
  logic [PtrW-1:0] rp;
  logic [CntW-1:0] count;

  assign room       = count <= CntW'(pb_pkg::Q_DEPTH - 2);
  assign head_valid = count != '0;
  assign head       = q[rp];

  // entry storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q[wp] <= push.c0;
    end
    if (push.n == 2'd2) begin
      q[wp + PtrW'(1)] <= push.c1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PtrW'(push.n);
      rp    <= rp + PtrW'(pop);
      count <= count + CntW'(push.n) - CntW'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> count <= CntW'(pb_pkg::Q_DEPTH - 2))
    else $error("command pushed without room");
`endif

endmodule

FILE: src/pb_back.sv
module pb_back #(
  parameter int MAX_PACKET = pb_pkg::MAX_PACKET_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  pb_pkg::wr_t  wr,
  input  logic         head_valid,
  input  pb_pkg::cmd_t head,
  output logic         pop,
  output pb_pkg::rel_t rel,
  pb_out_if.source     dout
);

  localparam int IdxW  = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
  localparam int Depth = 2 * (2 ** IdxW);

  typedef enum logic {
    B_HEAD,
    B_BODY
  } state_t;

  state_t          state;
  logic [IdxW-1:0] idx;
  logic [63:0]     acc;
  logic [2:0]      acc_cnt;
  logic            out_valid;
  logic [63:0]     out_bytes;
  logic [3:0]      byte_count;
  logic            last_of_item;
  logic            stream_done;

  pb_pkg::data_t   mem [Depth];
  pb_pkg::data_t   rd_data;
  logic            rd_en;
  logic [IdxW:0]   rd_addr;

  pb_pkg::data_t hdr;
  pb_pkg::data_t cur;
  logic          is_bank;
  logic          byte_v;
  logic          cmd_last;
  logic          item_end;
  logic          word_end;
  logic          out_free;
  logic          go;
  logic [63:0]   acc_ins;

  // literal store, two banks
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.idx[IdxW-1:0]}] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // byte selection for the current packet
  always_comb begin
    is_bank  = head.kind == pb_pkg::CMD_LIT_BANK;
    hdr      = (head.kind == pb_pkg::CMD_RUN) ? (8'd1 - head.len) : (head.len - 8'd1);
    byte_v   = (state == B_HEAD) ? head_valid : 1'b1;
    cur      = (state == B_HEAD) ? hdr : (is_bank ? rd_data : head.data);
    cmd_last = (state == B_BODY) && (!is_bank || (pb_pkg::len_t'(idx) == head.len - 8'd1));
    item_end = cmd_last && head.end_item;
    word_end = (acc_cnt == 3'd7) || item_end;
    out_free = !out_valid || dout.ready;
    go       = byte_v && (!word_end || out_free);
    acc_ins  = acc | (64'(cur) << {acc_cnt, 3'b000});
  end

  // store reads and command retire
  always_comb begin
    rd_en     = go && is_bank && ((state == B_HEAD) || !cmd_last);
    rd_addr   = {head.bank, (state == B_HEAD) ? IdxW'(0) : idx + IdxW'(1)};
    pop       = go && cmd_last;
    rel.valid = pop && is_bank;
    rel.bank  = head.bank;
  end

  // sequencer, packing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_HEAD;
      idx       <= '0;
      acc       <= '0;
      acc_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (dout.ready) begin
        out_valid <= 1'b0;
      end
      if (go) begin
        if (word_end) begin
          out_valid    <= 1'b1;
          out_bytes    <= acc_ins;
          byte_count   <= {1'b0, acc_cnt} + 4'd1;
          last_of_item <= item_end;
          stream_done  <= item_end && head.eos;
          acc          <= '0;
          acc_cnt      <= '0;
        end else begin
          acc     <= acc_ins;
          acc_cnt <= acc_cnt + 3'd1;
        end
        if (state == B_HEAD) begin
          state <= B_BODY;
          idx   <= '0;
        end else if (cmd_last) begin
          state <= B_HEAD;
        end else begin
          idx <= idx + IdxW'(1);
        end
      end
    end
  end

  assign dout.valid        = out_valid;
  assign dout.out_bytes    = out_bytes;
  assign dout.byte_count   = byte_count;
  assign dout.last_of_item = last_of_item;
  assign dout.stream_done  = stream_done;

`ifndef ASSERT_OFF
  a_body_has_cmd: assert property (@(posedge clk) disable iff (rst)
    state == B_BODY |-> head_valid)
    else $error("packet body with no command at queue head");
`endif

endmodule

FILE: src/packbits_encoder.sv
// PackBits run-length encoder, streaming.
// din takes one raw byte per transfer with an end-of-stream flag; dout gives
// result words of up to eight encoded bytes, first byte in bits 7:0, with a
// byte count, a last-of-item flag and a stream-done flag. An input that only
// grows the pending packet yields no word at all.
// The front classifies each byte against the pending packet combinationally
// and takes a byte every cycle while the four-entry command queue has room
// for two packets and, when a literal is handed over, the other store bank
// is free. The back sends one encoded byte per cycle unless a finished word
// waits on a stalled output register: a packet's header, then its stored
// bytes or the run byte; its speed sets the sustained rate. With the back
// idle, the first word of a packet passes from the queue through the packing
// accumulator into the output register; a word holds at most eight bytes.
// Reset (rst, synchronous) clears the pending packet, the queue and the
// output register; the literal store holds no valid data until written.
// When dout stalls, the output register holds its word, the back pauses,
// the queue fills and din then drops ready; no transfer is lost.
module packbits_encoder #(
  parameter int MAX_PACKET = pb_pkg::MAX_PACKET_DEF
) (
  input logic      clk,
  input logic      rst,
  pb_in_if.sink    din,
  pb_out_if.source dout
);

  pb_pkg::push_t push;
  pb_pkg::wr_t   wr;
  pb_pkg::rel_t  rel;
  pb_pkg::cmd_t  head;
  logic          head_valid;
  logic          room;
  logic          pop;

  pb_front #(.MAX_PACKET(MAX_PACKET)) u_front (
    .clk    (clk),
    .rst    (rst),
    .din    (din),
    .q_room (room),
    .rel    (rel),
    .push   (push),
    .wr     (wr)
  );

  pb_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  pb_back #(.MAX_PACKET(MAX_PACKET)) u_back (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rel        (rel),
    .dout       (dout)
  );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int MAX_PKT     = pb_pkg::MAX_PACKET_DEF;
  localparam int QUIET_LIMIT = 3000;

  // one encoded result word
  typedef struct {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
    logic        done;
  } enc_word_t;

  logic clk;
  logic rst;

  pb_in_if  din_if ();
  pb_out_if dout_if ();

  packbits_encoder dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  // encoder state as the testbench sees it
  logic          pending_run;
  int            pending_len;
  pb_pkg::data_t last_byte;
  pb_pkg::data_t literal_bytes [MAX_PKT];
  pb_pkg::data_t packet_bytes [$];
  enc_word_t     words_due [$];

  int  mismatches  = 0;
  int  quiet_cycles = 0;
  int  stall_left  = 0;
  bit  gaps_on     = 0;
  bit  stalls_on   = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // literal packet: header n-1, then the first n stored bytes
  function automatic void put_literal(int n);
    packet_bytes.push_back(pb_pkg::data_t'(n - 1));
    for (int i = 0; i < n; i++) packet_bytes.push_back(literal_bytes[i]);
  endfunction

  function automatic void flush_packet();
    if (pending_len == 0) return;
    if (pending_run) begin
      packet_bytes.push_back(pb_pkg::data_t'(257 - pending_len));
      packet_bytes.push_back(literal_bytes[0]);
    end else begin
      put_literal(pending_len);
    end
    pending_len = 0;
    pending_run = 1'b0;
  endfunction

  function automatic void open_literal(pb_pkg::data_t b);
    literal_bytes[0] = b;
    pending_len = 1;
    pending_run = 1'b0;
  endfunction

  // work out the result words that one accepted byte causes
  function automatic void encode_byte(pb_pkg::data_t b, logic eos);
    int        nwords;
    int        cnt;
    enc_word_t w;
    packet_bytes.delete();
    if (pending_len == 0) begin
      open_literal(b);
    end else if (pending_len >= MAX_PKT) begin
      flush_packet();
      open_literal(b);
    end else if (b == last_byte) begin
      if (pending_run) begin
        pending_len++;
      end else begin
        // repeated byte leaves the literal and starts a run of two
        if (pending_len >= 2) put_literal(pending_len - 1);
        literal_bytes[0] = b;
        pending_len = 2;
        pending_run = 1'b1;
      end
    end else if (pending_run) begin
      flush_packet();
      open_literal(b);
    end else begin
      literal_bytes[pending_len] = b;
      pending_len++;
    end
    last_byte = b;
    if (eos) flush_packet();

    // pack eight bytes per word, low byte first
    nwords = (packet_bytes.size() + 7) / 8;
    for (int k = 0; k < nwords; k++) begin
      cnt = packet_bytes.size() - 8 * k;
      if (cnt > 8) cnt = 8;
      w.bytes = '0;
      for (int i = 0; i < cnt; i++) w.bytes[8*i +: 8] = packet_bytes[8*k + i];
      w.count = 4'(cnt);
      w.last  = (k + 1 == nwords);
      w.done  = (k + 1 == nwords) && eos;
      words_due.push_back(w);
    end
  endfunction

  // predict on every input transfer
  always @(posedge clk) begin
    if (!rst && din_if.valid && din_if.ready)
      encode_byte(din_if.data_byte, din_if.end_of_stream);
  end

  // compare each output transfer with the oldest expected word
  always @(posedge clk) begin
    enc_word_t w;
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word bytes=%h count=%0d last=%b done=%b", $realtime,
                   dout_if.out_bytes, dout_if.byte_count, dout_if.last_of_item,
                   dout_if.stream_done);
      end else begin
        w = words_due.pop_front();
        if (dout_if.out_bytes !== w.bytes || dout_if.byte_count !== w.count ||
            dout_if.last_of_item !== w.last || dout_if.stream_done !== w.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                     $realtime, w.bytes, w.count, w.last, w.done, dout_if.out_bytes,
                     dout_if.byte_count, dout_if.last_of_item, dout_if.stream_done);
        end
      end
    end
  end

  // output stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      dout_if.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      dout_if.ready <= 1'b0;
    end else begin
      dout_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hand one byte to the encoder and wait for the transfer
  task automatic send_byte(input pb_pkg::data_t b, input logic eos);
    din_if.valid <= 1'b1;
    din_if.data_byte <= b;
    din_if.end_of_stream <= eos;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      din_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // hold off input until every expected word has come out
  task automatic wait_for_words();
    din_if.valid <= 1'b0;
    @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // message with runs, splits and literals drawn from a few symbols
  task automatic send_message(input int len);
    pb_pkg::data_t sym [3];
    pb_pkg::data_t b;
    for (int i = 0; i < 3; i++) sym[i] = pb_pkg::data_t'($urandom);
    b = sym[0];
    for (int i = 0; i < len; i++) begin
      if (i == 0 || $urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 4) == 0) b = pb_pkg::data_t'($urandom);
        else b = sym[$urandom_range(0, 2)];
      end
      send_byte(b, i == len - 1);
    end
  endtask

  // one-byte messages, extremes, and a message opening on the old last byte
  task automatic test_single_bytes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(8'h55, 1'b1);
  endtask

  // literal split by a repeat, run closed by a new byte
  task automatic test_literal_split();
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
  endtask

  // single byte turned into a run of two, and a run ended by end of stream
  task automatic test_short_runs();
    send_byte(8'ha5, 1'b0);
    send_byte(8'ha5, 1'b1);
    send_byte(8'h5a, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'h5a, 1'b1);
  endtask

  // full literal flushed before the next byte, even when that byte repeats
  task automatic test_full_packets();
    for (int i = 0; i < MAX_PKT; i++) send_byte(pb_pkg::data_t'(i), 1'b0);
    send_byte(pb_pkg::data_t'(MAX_PKT - 1), 1'b1);
  endtask

  // random messages, idling switched per message, one full pause midway
  task automatic test_random_messages();
    int sent;
    int len;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < 24) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 8);
      send_message(len);
      sent += len;
      if (!paused && sent >= 12) begin
        wait_for_words();
        paused = 1;
      end
    end
  endtask

  // back-to-back stream with no idling on either side
  task automatic test_steady_stream();
    gaps_on = 0;
    stalls_on = 0;
    for (int i = 0; i < 3; i++) send_message($urandom_range(1, 5));
  endtask

  initial begin
    pending_run = 1'b0;
    pending_len = 0;
    last_byte   = '0;
    rst <= 1'b1;
    din_if.valid <= 1'b0;
    din_if.data_byte <= '0;
    din_if.end_of_stream <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    gaps_on = 1;
    stalls_on = 1;
    test_single_bytes();
    test_literal_split();
    test_short_runs();
    test_full_packets();
    test_random_messages();
    test_steady_stream();

    // drain and let any stray word show up
    din_if.valid <= 1'b0;
    @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
src/pb_pkg.sv
src/pb_if.sv
src/pb_front.sv
src/pb_cmd_queue.sv
src/pb_back.sv
src/packbits_encoder.sv
dv/tb.sv
